// File: rtl/tdpt_pkg.sv
// ----------------------------------------------------------------------------
// tdpt_pkg
// Shared types for the trial-division prime test: controller states and the
// command / status bundles passed between controller and datapath.
// ----------------------------------------------------------------------------
package tdpt_pkg;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_DIV,
        S_EVAL,
        S_HOLD
    } t_state;

    // Controller -> datapath commands
    typedef struct packed {
        logic load;       // capture magnitude of the input, divisor = 2
        logic div_start;  // load dividend, clear remainder and bit counter
        logic div_step;   // one restoring-division bit
        logic next_div;   // advance the trial divisor by one
    } t_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic mag_le_one; // magnitude is 0 or 1
        logic div_last;   // this division step is the final bit
        logic past_root;  // quotient below divisor: no factor up to the root
        logic exact;      // remainder is zero
    } t_sts;

endpackage

// File: rtl/tdpt_dpath.sv
// ----------------------------------------------------------------------------
// tdpt_dpath
// Datapath: magnitude register, trial divisor counter and a one-bit-per-cycle
// restoring divider producing quotient and remainder of magnitude / divisor.
// ----------------------------------------------------------------------------
module tdpt_dpath
    import tdpt_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts
);

    localparam int CNT_W = $clog2(DATA_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);
    localparam logic [DATA_WIDTH-1:0] FIRST_DIV = DATA_WIDTH'(2);

    logic [DATA_WIDTH-1:0] r_mag;
    logic [DATA_WIDTH-1:0] r_dvs;
    logic [DATA_WIDTH-1:0] r_quo;
    logic [DATA_WIDTH-1:0] r_rem;
    logic [CNT_W-1:0]      r_cnt;

    logic [DATA_WIDTH-1:0] n_mag;
    logic [DATA_WIDTH:0]   w_trial;

    // Two's complement magnitude; the most negative value maps to 2^(W-1)
    assign n_mag = i_value[DATA_WIDTH-1] ? (~i_value + 1'b1) : i_value;

    // Partial remainder with the next dividend bit, minus the divisor
    assign w_trial = {r_rem, r_quo[DATA_WIDTH-1]} - {1'b0, r_dvs};

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag <= n_mag;
            r_dvs <= FIRST_DIV;
        end else if (i_cmd.next_div) begin
            r_dvs <= r_dvs + 1'b1;
        end

        if (i_cmd.div_start) begin
            r_quo <= r_mag;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 1'b1;
            if (!w_trial[DATA_WIDTH]) begin
                r_rem <= w_trial[DATA_WIDTH-1:0];
                r_quo <= {r_quo[DATA_WIDTH-2:0], 1'b1};
            end else begin
                r_rem <= {r_rem[DATA_WIDTH-2:0], r_quo[DATA_WIDTH-1]};
                r_quo <= {r_quo[DATA_WIDTH-2:0], 1'b0};
            end
        end
    end

    // Status back to the controller
    assign o_sts.mag_le_one = (r_mag[DATA_WIDTH-1:1] == '0);
    assign o_sts.div_last   = (r_cnt == CNT_LAST);
    assign o_sts.past_root  = (r_quo < r_dvs);
    assign o_sts.exact      = (r_rem == '0);

endmodule

// File: rtl/tdpt_ctrl.sv
// ----------------------------------------------------------------------------
// tdpt_ctrl
// Controller: sequences load, divisions and checks, and owns the output
// register holding the result beat until the consumer takes it.
// ----------------------------------------------------------------------------
module tdpt_ctrl
    import tdpt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    output logic o_valid,
    output logic o_is_prime,
    input  logic i_stall,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    t_state r_state;
    t_state n_state;
    logic   r_res;
    logic   n_res;
    logic   r_out_valid;
    logic   r_out_prime;
    logic   w_out_load;

    // State and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_res <= n_res;
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        n_res      = r_res;
        o_cmd      = '0;
        w_out_load = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                if (i_sts.mag_le_one) begin
                    n_res   = 1'b1;
                    n_state = S_HOLD;
                end else begin
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (i_sts.past_root) begin
                    n_res   = 1'b1;
                    n_state = S_HOLD;
                end else if (i_sts.exact) begin
                    n_res   = 1'b0;
                    n_state = S_HOLD;
                end else begin
                    o_cmd.next_div  = 1'b1;
                    o_cmd.div_start = 1'b1;
                    n_state         = S_DIV;
                end
            end
            S_HOLD: begin
                // wait for a free output register
                if (!r_out_valid || !i_stall) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_out_load) begin
            r_out_prime <= r_res;
        end
    end

    assign o_stall    = (r_state != S_IDLE);
    assign o_valid    = r_out_valid;
    assign o_is_prime = r_out_prime;

endmodule

// File: rtl/trial_division_prime_test_top.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test_top
// Reports whether the magnitude of a signed integer is prime (0 and 1 count
// as prime) by trial division with a bit-serial divider.
//
//   channel   direction   handshake            payload
//   input     in          i_valid / o_stall    i_value [DATA_WIDTH-1:0]
//   result    out         o_valid / i_stall    o_is_prime
//
// Magnitudes 0 and 1 go from accept to the result load after the magnitude
// check. Otherwise each trial divisor d = 2, 3, ... runs a full division in
// the restoring divider and then an evaluation; the search stops at the
// smallest factor or once d exceeds magnitude / d, so k divisors are tried
// with k <= sqrt(magnitude). Synchronous active-low
// reset returns to idle with no result pending. The next beat is accepted as
// soon as the result sits in the output register, even if it is stalled.
// ----------------------------------------------------------------------------
module trial_division_prime_test_top
    import tdpt_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic [DATA_WIDTH-1:0] i_value,
    output logic                  o_stall,
    output logic                  o_valid,
    output logic                  o_is_prime,
    input  logic                  i_stall
);

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer
    tdpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .o_is_prime (o_is_prime),
        .i_stall    (i_stall),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    // Divider datapath
    tdpt_dpath #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_value (i_value),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts)
    );

`ifndef ASSERT_OFF
    // An accepted beat closes the input until its result is loaded
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input not stalled after accept");

    // A load is followed by the magnitude check, never a division step
    a_load_then_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load |=> !w_cmd.div_step)
        else $error("division step right after load");

    // Moving to the next divisor always restarts the divider
    a_next_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.next_div |-> (w_cmd.div_start && !w_cmd.div_step))
        else $error("divisor advanced without divider restart");
`endif

endmodule
